### rtl/rfpe_pkg.sv
// Shared types and constants of the remote frame pulse encoder.
// No dependencies; every other file of the block imports this package.
package rfpe_pkg;

  // Frame key byte and nibble mask used by the frame builder.
  localparam logic [7:0] KEY_BYTE    = 8'hA7;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // Configuration register reset values.
  localparam logic [11:0] SYMBOL_US_RST         = 12'd640;
  localparam logic [16:0] WAKE_HIGH_US_RST      = 17'd9415;
  localparam logic [16:0] WAKE_LOW_US_RST       = 17'd89565;
  localparam logic [16:0] SOFT_SYNC_US_RST      = 17'd4550;
  localparam logic [16:0] GAP_US_RST            = 17'd30415;
  localparam logic [3:0]  FIRST_SYNC_COUNT_RST  = 4'd2;
  localparam logic [3:0]  REPEAT_SYNC_COUNT_RST = 4'd7;

  // Register indexes (byte address is four times the index).
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_SYMBOL_US         = 3'd0;
  localparam logic [2:0] REG_WAKE_HIGH_US      = 3'd1;
  localparam logic [2:0] REG_WAKE_LOW_US       = 3'd2;
  localparam logic [2:0] REG_SOFT_SYNC_US      = 3'd3;
  localparam logic [2:0] REG_GAP_US            = 3'd4;
  localparam logic [2:0] REG_FIRST_SYNC_COUNT  = 3'd5;
  localparam logic [2:0] REG_REPEAT_SYNC_COUNT = 3'd6;

  // Number of data bits in one frame.
  localparam logic [5:0] FRAME_BITS = 6'd56;

  // Commands carried in the input tuser.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef struct packed {
    logic [11:0] symbol_us;
    logic [16:0] wake_high_us;
    logic [16:0] wake_low_us;
    logic [16:0] soft_sync_us;
    logic [16:0] gap_us;
    logic [3:0]  first_sync_count;
    logic [3:0]  repeat_sync_count;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [3:0]  button;
    logic [15:0] roll_code;
    logic [23:0] remote;
    logic        first_frame;
  } in_item_t;

  typedef struct packed {
    logic [16:0] duration_us;
    logic        level;
    logic        last_of_frame;
    logic [55:0] frame_bits;
  } pulse_t;

endpackage

### rtl/rfpe_cfg_regs.sv
// APB-style configuration registers of the remote frame pulse encoder.
// Depends on rfpe_pkg for the register indexes, reset values and cfg_t.
module rfpe_cfg_regs
  import rfpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg        = cfg_r;

  // Register writes in the access phase; values are cut to register width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_us         <= SYMBOL_US_RST;
      cfg_r.wake_high_us      <= WAKE_HIGH_US_RST;
      cfg_r.wake_low_us       <= WAKE_LOW_US_RST;
      cfg_r.soft_sync_us      <= SOFT_SYNC_US_RST;
      cfg_r.gap_us            <= GAP_US_RST;
      cfg_r.first_sync_count  <= FIRST_SYNC_COUNT_RST;
      cfg_r.repeat_sync_count <= REPEAT_SYNC_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SYMBOL_US:         cfg_r.symbol_us         <= cfg_pwdata[11:0];
        REG_WAKE_HIGH_US:      cfg_r.wake_high_us      <= cfg_pwdata[16:0];
        REG_WAKE_LOW_US:       cfg_r.wake_low_us       <= cfg_pwdata[16:0];
        REG_SOFT_SYNC_US:      cfg_r.soft_sync_us      <= cfg_pwdata[16:0];
        REG_GAP_US:            cfg_r.gap_us            <= cfg_pwdata[16:0];
        REG_FIRST_SYNC_COUNT:  cfg_r.first_sync_count  <= cfg_pwdata[3:0];
        REG_REPEAT_SYNC_COUNT: cfg_r.repeat_sync_count <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back multiplexer; the unused address reads as zero.
  always_comb begin
    unique case (reg_idx)
      REG_SYMBOL_US:         cfg_prdata = {20'd0, cfg_r.symbol_us};
      REG_WAKE_HIGH_US:      cfg_prdata = {15'd0, cfg_r.wake_high_us};
      REG_WAKE_LOW_US:       cfg_prdata = {15'd0, cfg_r.wake_low_us};
      REG_SOFT_SYNC_US:      cfg_prdata = {15'd0, cfg_r.soft_sync_us};
      REG_GAP_US:            cfg_prdata = {15'd0, cfg_r.gap_us};
      REG_FIRST_SYNC_COUNT:  cfg_prdata = {28'd0, cfg_r.first_sync_count};
      REG_REPEAT_SYNC_COUNT: cfg_prdata = {28'd0, cfg_r.repeat_sync_count};
      default:               cfg_prdata = 32'd0;
    endcase
  end

endmodule

### rtl/rfpe_frame_build.sv
// Combinational frame builder: key byte, checksum nibble and running XOR.
// Depends on rfpe_pkg for the key byte and nibble mask.
module rfpe_frame_build
  import rfpe_pkg::*;
(
  input  logic [3:0]  button,
  input  logic [15:0] roll_code,
  input  logic [23:0] remote,
  output logic [55:0] frame
);

  logic [7:0] plain [7];
  logic [7:0] obf   [7];
  logic [7:0] sum;

  always_comb begin
    plain[0] = KEY_BYTE;
    plain[1] = {button, 4'h0};
    plain[2] = roll_code[15:8];
    plain[3] = roll_code[7:0];
    plain[4] = remote[23:16];
    plain[5] = remote[15:8];
    plain[6] = remote[7:0];

    // Checksum is the XOR of all fourteen nibbles of the plain frame.
    sum = 8'd0;
    for (int k = 0; k < 7; k++) begin
      sum = sum ^ plain[k] ^ {4'h0, plain[k][7:4]};
    end
    plain[1] = plain[1] | {4'h0, sum[3:0] & NIBBLE_MASK};

    // Each byte from the second on is XORed with the obfuscated byte before it.
    obf[0] = plain[0];
    for (int k = 1; k < 7; k++) begin
      obf[k] = plain[k] ^ obf[k-1];
    end

    frame = {obf[0], obf[1], obf[2], obf[3], obf[4], obf[5], obf[6]};
  end

endmodule

### rtl/rfpe_pulse_seq.sv
// Pulse sequencer: frame and segment state; one pulse per start or in-frame item.
// Depends on rfpe_pkg and instantiates rfpe_frame_build.
module rfpe_pulse_seq
  import rfpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  in_item_t item,
  input  cfg_t     cfg,
  output logic     res_valid,
  output pulse_t   res
);

  typedef enum logic [7:0] {
    SEG_WAKE_H = 8'b0000_0001,
    SEG_WAKE_L = 8'b0000_0010,
    SEG_SYNC_H = 8'b0000_0100,
    SEG_SYNC_L = 8'b0000_1000,
    SEG_SOFT_H = 8'b0001_0000,
    SEG_SOFT_L = 8'b0010_0000,
    SEG_DATA   = 8'b0100_0000,
    SEG_GAP    = 8'b1000_0000
  } seg_t;

  function automatic seg_t after_wake(input logic [3:0] syncs);
    return (syncs != 4'd0) ? SEG_SYNC_H : SEG_SOFT_H;
  endfunction

  logic [55:0] frame_store_r, frame_store_nxt;
  seg_t        seg_r, seg_nxt;
  logic [3:0]  syncs_left_r, syncs_left_nxt;
  logic [5:0]  bit_position_r, bit_position_nxt;
  logic        second_half_r, second_half_nxt;
  logic        busy_r, busy_nxt;

  logic [55:0] new_frame;
  logic        start;
  logic [55:0] fs_eff;
  seg_t        seg_eff;
  logic [3:0]  syncs_eff;
  logic [5:0]  pos_eff;
  logic        half_eff;
  logic [5:0]  pos;
  logic [5:0]  pos_inc;
  logic        data_bit;
  logic [16:0] sym_dur;
  logic [16:0] sync_dur;

  rfpe_frame_build u_frame_build (
    .button    (item.button),
    .roll_code (item.roll_code),
    .remote    (item.remote),
    .frame     (new_frame)
  );

  assign start     = (item.command == CMD_START);
  assign res_valid = item_valid & (start | busy_r);
  assign sym_dur   = {5'd0, cfg.symbol_us};
  assign sync_dur  = {3'd0, cfg.symbol_us, 2'b00};

  // A start loads fresh frame state before the pulse is worked out.
  always_comb begin
    if (start) begin
      fs_eff    = new_frame;
      syncs_eff = item.first_frame ? cfg.first_sync_count : cfg.repeat_sync_count;
      pos_eff   = 6'd0;
      half_eff  = 1'b0;
      seg_eff   = item.first_frame ? SEG_WAKE_H : after_wake(syncs_eff);
    end else begin
      fs_eff    = frame_store_r;
      syncs_eff = syncs_left_r;
      pos_eff   = bit_position_r;
      half_eff  = second_half_r;
      seg_eff   = seg_r;
    end
  end

  // Data bit select, most significant bit first.
  assign pos      = (pos_eff < FRAME_BITS) ? pos_eff : (FRAME_BITS - 6'd1);
  assign pos_inc  = pos + 6'd1;
  assign data_bit = fs_eff[(FRAME_BITS - 6'd1) - pos];

  // Pulse of the current segment and the step to the next one.
  always_comb begin
    frame_store_nxt     = fs_eff;
    syncs_left_nxt      = syncs_eff;
    bit_position_nxt    = pos_eff;
    second_half_nxt     = half_eff;
    seg_nxt             = seg_eff;
    busy_nxt            = 1'b1;
    res.duration_us     = 17'd0;
    res.level           = 1'b0;
    res.last_of_frame   = 1'b0;
    res.frame_bits      = fs_eff;
    unique case (seg_eff)
      SEG_WAKE_H: begin
        res.duration_us = cfg.wake_high_us;
        res.level       = 1'b1;
        seg_nxt         = SEG_WAKE_L;
      end
      SEG_WAKE_L: begin
        res.duration_us = cfg.wake_low_us;
        seg_nxt         = after_wake(syncs_eff);
      end
      SEG_SYNC_H: begin
        res.duration_us = sync_dur;
        res.level       = 1'b1;
        seg_nxt         = SEG_SYNC_L;
      end
      SEG_SYNC_L: begin
        res.duration_us = sync_dur;
        syncs_left_nxt  = syncs_eff - 4'd1;
        seg_nxt         = after_wake(syncs_left_nxt);
      end
      SEG_SOFT_H: begin
        res.duration_us = cfg.soft_sync_us;
        res.level       = 1'b1;
        seg_nxt         = SEG_SOFT_L;
      end
      SEG_SOFT_L: begin
        res.duration_us  = sym_dur;
        seg_nxt          = SEG_DATA;
        bit_position_nxt = 6'd0;
        second_half_nxt  = 1'b0;
      end
      SEG_DATA: begin
        // A one is sent low then high, a zero high then low.
        res.duration_us = sym_dur;
        res.level       = half_eff ? data_bit : ~data_bit;
        if (half_eff) begin
          bit_position_nxt = pos_inc;
          if (pos_inc >= FRAME_BITS) begin
            seg_nxt = SEG_GAP;
          end
        end
        second_half_nxt = ~half_eff;
      end
      SEG_GAP: begin
        res.duration_us   = cfg.gap_us;
        res.last_of_frame = 1'b1;
        busy_nxt          = 1'b0;
        seg_nxt           = SEG_WAKE_H;
      end
      default: begin
      end
    endcase
  end

  // State advances only on items that produce a pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_store_r  <= 56'd0;
      seg_r          <= SEG_WAKE_H;
      syncs_left_r   <= 4'd0;
      bit_position_r <= 6'd0;
      second_half_r  <= 1'b0;
      busy_r         <= 1'b0;
    end else if (res_valid) begin
      frame_store_r  <= frame_store_nxt;
      seg_r          <= seg_nxt;
      syncs_left_r   <= syncs_left_nxt;
      bit_position_r <= bit_position_nxt;
      second_half_r  <= second_half_nxt;
      busy_r         <= busy_nxt;
    end
  end

  a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.last_of_frame |-> !res.level)
    else $error("closing gap pulse is not low");

  a_gap_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.last_of_frame |=> !busy_r)
    else $error("sequencer still busy after the closing gap");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_position_r <= FRAME_BITS)
    else $error("bit position beyond the frame");

  a_half_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    second_half_r |-> seg_r == SEG_DATA)
    else $error("second half flag set outside the data segment");

endmodule

### rtl/rts_remote_frame_pulse_encoder_unit.sv
// Top level of the remote frame pulse encoder: input register, sequencer, result register.
// Depends on rfpe_pkg and instantiates rfpe_cfg_regs and rfpe_pulse_seq.

// A start beat builds the 56-bit obfuscated frame and returns its first pulse; each
// following next beat returns the next pulse of the train (wake-up on a first frame only,
// hardware sync pairs, software sync, 56 Manchester bits, closing gap with tlast set), and
// a next beat while no frame is running returns nothing. The block takes one beat per clock
// cycle while the output side does not stall; each pulse passes from the input register
// through the sequencer logic into the result register, which holds a pulse while the
// output side stalls. Registers should be written only while no frame is in flight.
module rts_remote_frame_pulse_encoder_unit
  import rfpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: button[3:0], roll_code[19:4], remote[43:20], first_frame[44], zero[47:45]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,
  // in_tuser: command[0]
  input  logic              in_tuser,
  // out_tdata: duration_us[16:0], level[17], frame_bits[73:18], zero[79:74]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [79:0]       out_tdata,
  // out_tlast: last_of_frame
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t     cfg;
  in_item_t s1_item_r;
  logic     s1_valid_r, s1_valid_nxt;
  logic     out_valid_r, out_valid_nxt;
  pulse_t   out_pulse_r;
  logic     out_free;
  logic     advance;
  logic     in_fire;
  logic     seq_valid;
  pulse_t   seq_pulse;

  rfpe_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rfpe_pulse_seq u_pulse_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .item       (s1_item_r),
    .cfg        (cfg),
    .res_valid  (seq_valid),
    .res        (seq_pulse)
  );

  // Flow control: the input stage moves on whenever the result register can take a pulse.
  assign out_free  = ~out_valid_r | out_tready;
  assign advance   = s1_valid_r & out_free;
  assign in_tready = ~s1_valid_r | out_free;
  assign in_fire   = in_tvalid & in_tready;

  assign s1_valid_nxt  = in_fire | (s1_valid_r & ~advance);
  assign out_valid_nxt = out_free ? (advance & seq_valid) : out_valid_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.command     <= in_tuser;
      s1_item_r.button      <= in_tdata[3:0];
      s1_item_r.roll_code   <= in_tdata[19:4];
      s1_item_r.remote      <= in_tdata[43:20];
      s1_item_r.first_frame <= in_tdata[44];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && seq_valid) begin
      out_pulse_r <= seq_pulse;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_pulse_r.last_of_frame;
  assign out_tdata  = {6'd0, out_pulse_r.frame_bits, out_pulse_r.level,
                       out_pulse_r.duration_us};

endmodule
